>>> rtl/matrix3_inverse_unit_assert.svh
// ----------------------------------------------------------------------------
// matrix3_inverse_unit assertion macros
// Shared concurrent assertion forms for the 3x3 inverse unit checkers.
// ----------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3_INVERSE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define M3INV_ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("m3inv assertion failed");

// next-cycle implication, disabled in reset
`define M3INV_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("m3inv assertion failed");

// implication checked through reset
`define M3INV_ASSERT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |-> (c)) \
    else $error("m3inv assertion failed");

`endif

>>> rtl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Types and constants of the 3x3 matrix inverse unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package m3inv_pkg;

  localparam int ELEM_W  = 32;
  localparam int N_ELEM  = 9;
  localparam int PROD_W  = 64;
  localparam int ADJ_W   = 65;
  localparam int PPART_W = 97;
  localparam int DET_W   = 99;
  localparam int QB      = 33;
  localparam int THR_W   = 31;

  localparam logic [THR_W-1:0]  THR_RESET = 31'd168;
  localparam logic [ELEM_W-1:0] SAT_POS   = 32'h7fff_ffff;
  localparam logic [ELEM_W-1:0] SAT_NEG   = 32'h8000_0000;

  localparam int USER_SING = 0;
  localparam int USER_SAT  = 1;

  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ADJ_W-1:0]   adj_t;
  typedef logic signed [DET_W-1:0]   det_t;

  // cofactor k = m[CA]*m[CB] - m[CC]*m[CD]
  localparam int CA [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CB [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CC [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CD [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

>>> rtl/matrix3_inverse_unit.sv
// Throughput: one matrix per cycle; a stalled output freezes the whole pipe.
// The quotient pipe resolves one bit per stage, 33 stages for nine lanes.
// Reset: all valid bits clear, det_threshold returns to 168.
// ----------------------------------------------------------------------------
// matrix3_inverse_unit
// Pipelined 3x3 fixed-point inverse by adjugate and rounded division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3_inverse_unit
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [THR_W-1:0]           cfg_wr_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (32 bits each, from bit 0)
  input  logic [N_ELEM*ELEM_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (32 bits each, from bit 0)
  output logic [N_ELEM*ELEM_W-1:0]   out_tdata,
  // singular, saturated (from bit 0)
  output logic [1:0]                 out_tuser
);

  localparam int NW = ADJ_W + 2 * FRAC_BITS;
  localparam int CW = (NW > DET_W + QB) ? NW : DET_W + QB;

  logic en;
  logic [THR_W-1:0] thr_r;
  logic [7:1] v_r;
  logic dv_r [0:QB];
  logic vr_r, ov_r;

  elem_t m1_r [0:8];
  prod_t pa2_r [0:8], pb2_r [0:8];
  elem_t mr2_r [0:2], mr3_r [0:2];
  adj_t adj3_r [0:8], adj4_r [0:8], adj5_r [0:8], adj6_r [0:8];
  adj_t plo4_r [0:2], phi4_r [0:2];
  det_t prod5_r [0:2];
  det_t det6_r;

  logic [DET_W-1:0] den7_r;
  logic dneg7_r, sing7_r;
  logic [NW-1:0] num7_r [0:8];
  logic [8:0] cneg7_r;

  logic [NW-1:0] rem_r [0:QB][0:8];
  logic [QB-1:0] q_r [0:QB][0:8];
  logic [DET_W-1:0] den_r [0:QB];
  logic dneg_r [0:QB], sing_r [0:QB];
  logic [8:0] cneg_r [0:QB], ovf_r [0:QB];

  logic [NW-1:0] rem_nxt [0:QB-1][0:8];
  logic [QB-1:0] q_nxt [0:QB-1][0:8];

  logic [QB:0] qr_r [0:8];
  logic [8:0] rcneg_r, rovf_r;
  logic rdneg_r, rsing_r;

  logic [N_ELEM*ELEM_W-1:0] out_data_r, out_data_nxt;
  logic [1:0] out_user_r, out_user_nxt;

  logic [DET_W-1:0] dmag6;
  logic [8:0] ovf_nxt;

  assign en         = !ov_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = ov_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vr_r <= 1'b0;
      ov_r <= 1'b0;
      for (int s = 0; s <= QB; s++) dv_r[s] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_tvalid;
      for (int s = 2; s <= 7; s++) v_r[s] <= v_r[s-1];
      dv_r[0] <= v_r[7];
      for (int s = 1; s <= QB; s++) dv_r[s] <= dv_r[s-1];
      vr_r <= dv_r[QB];
      ov_r <= vr_r;
    end
  end

  assign dmag6 = det6_r[DET_W-1] ? DET_W'(-det6_r) : DET_W'(det6_r);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ovf_nxt[k] = CW'(num7_r[k]) >= (CW'(den7_r) << QB);
    end
  end

  always_comb begin
    for (int s = 0; s < QB; s++) begin
      for (int k = 0; k < 9; k++) begin
        rem_nxt[s][k] = rem_r[s][k];
        q_nxt[s][k]   = q_r[s][k];
        if (CW'(rem_r[s][k]) >= (CW'(den_r[s]) << (QB - 1 - s))) begin
          rem_nxt[s][k] = rem_r[s][k] - NW'(CW'(den_r[s]) << (QB - 1 - s));
          q_nxt[s][k][QB-1-s] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic rneg;
    logic [ELEM_W-1:0] val;
    logic sat;
    sat = 1'b0;
    out_data_nxt = '0;
    for (int k = 0; k < 9; k++) begin
      rneg = rcneg_r[k] ^ rdneg_r;
      val  = '0;
      if (rsing_r) begin
        val = (k % 4 == 0) ? (ELEM_W'(1) << FRAC_BITS) : '0;
      end else if (rovf_r[k] || (rneg && qr_r[k] > (QB+1)'(SAT_NEG))
                   || (!rneg && qr_r[k] > (QB+1)'(SAT_POS))) begin
        val = rneg ? SAT_NEG : SAT_POS;
        sat = 1'b1;
      end else begin
        val = rneg ? (ELEM_W'(0) - qr_r[k][ELEM_W-1:0]) : qr_r[k][ELEM_W-1:0];
      end
      out_data_nxt[k*ELEM_W +: ELEM_W] = val;
    end
    out_user_nxt = '0;
    out_user_nxt[USER_SING] = rsing_r;
    out_user_nxt[USER_SAT]  = sat && !rsing_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) m1_r[k] <= elem_t'(in_tdata[k*ELEM_W +: ELEM_W]);

      for (int k = 0; k < 9; k++) begin
        pa2_r[k] <= m1_r[CA[k]] * m1_r[CB[k]];
        pb2_r[k] <= m1_r[CC[k]] * m1_r[CD[k]];
      end
      for (int j = 0; j < 3; j++) mr2_r[j] <= m1_r[j];

      for (int k = 0; k < 9; k++) adj3_r[k] <= adj_t'(pa2_r[k]) - adj_t'(pb2_r[k]);
      for (int j = 0; j < 3; j++) mr3_r[j] <= mr2_r[j];

      for (int j = 0; j < 3; j++) begin
        plo4_r[j] <= mr3_r[j] * adj_t'($signed({1'b0, adj3_r[3*j][31:0]}));
        phi4_r[j] <= mr3_r[j] * adj_t'($signed(adj3_r[3*j][ADJ_W-1:32]));
      end
      adj4_r <= adj3_r;

      for (int j = 0; j < 3; j++) begin
        prod5_r[j] <= det_t'($signed({phi4_r[j][PPART_W-33:0], 32'd0}))
                      + det_t'(plo4_r[j]);
      end
      adj5_r <= adj4_r;

      det6_r <= prod5_r[0] + prod5_r[1] + prod5_r[2];
      adj6_r <= adj5_r;

      den7_r  <= dmag6;
      dneg7_r <= det6_r[DET_W-1];
      sing7_r <= (CW'(thr_r) << (2 * FRAC_BITS)) >= CW'(dmag6);
      for (int k = 0; k < 9; k++) begin
        cneg7_r[k] <= adj6_r[k][ADJ_W-1];
        num7_r[k]  <= NW'(adj6_r[k][ADJ_W-1] ? ADJ_W'(-adj6_r[k]) : ADJ_W'(adj6_r[k]))
                      << (2 * FRAC_BITS);
      end

      den_r[0]  <= den7_r;
      dneg_r[0] <= dneg7_r;
      sing_r[0] <= sing7_r;
      cneg_r[0] <= cneg7_r;
      ovf_r[0]  <= ovf_nxt;
      for (int k = 0; k < 9; k++) begin
        rem_r[0][k] <= num7_r[k];
        q_r[0][k]   <= '0;
      end

      for (int s = 0; s < QB; s++) begin
        den_r[s+1]  <= den_r[s];
        dneg_r[s+1] <= dneg_r[s];
        sing_r[s+1] <= sing_r[s];
        cneg_r[s+1] <= cneg_r[s];
        ovf_r[s+1]  <= ovf_r[s];
        for (int k = 0; k < 9; k++) begin
          rem_r[s+1][k] <= rem_nxt[s][k];
          q_r[s+1][k]   <= q_nxt[s][k];
        end
      end

      for (int k = 0; k < 9; k++) begin
        qr_r[k] <= (QB+1)'(q_r[QB][k])
                   + (QB+1)'((CW'(rem_r[QB][k]) << 1) >= CW'(den_r[QB]));
      end
      rcneg_r <= cneg_r[QB];
      rovf_r  <= ovf_r[QB];
      rdneg_r <= dneg_r[QB];
      rsing_r <= sing_r[QB];

      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

>>> rtl/m3inv_chk.sv
// ----------------------------------------------------------------------------
// m3inv_chk
// Port-level checks of the 3x3 inverse unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix3_inverse_unit_assert.svh"

module m3inv_chk
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     cfg_wr_en,
  input logic [THR_W-1:0]         cfg_wr_data,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic [N_ELEM*ELEM_W-1:0] in_tdata,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [N_ELEM*ELEM_W-1:0] out_tdata,
  input logic [1:0]               out_tuser
);

  logic [N_ELEM*ELEM_W-1:0] ident;
  logic unused;

  always_comb begin
    ident = '0;
    for (int k = 0; k < 9; k += 4) ident[k*ELEM_W +: ELEM_W] = ELEM_W'(1) << FRAC_BITS;
  end

  assign unused = cfg_wr_en ^ (^cfg_wr_data) ^ in_tvalid ^ (^in_tdata);

  `M3INV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `M3INV_ASSERT_IMPLY(a_sing_ident, clk, rst_n, out_tvalid && out_tuser[USER_SING],
    out_tdata == ident && !out_tuser[USER_SAT])
  `M3INV_ASSERT_IMPLY(a_ready_free, clk, rst_n, !out_tvalid || out_tready, in_tready)
  `M3INV_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n), !out_tvalid)

endmodule

bind matrix3_inverse_unit m3inv_chk #(.FRAC_BITS(FRAC_BITS)) u_m3inv_chk (.*);
